@@ src/mtc_pkg.sv @@
// Shared types, character constants and Morse lookup functions for the Morse text codec.
`default_nettype none

package mtc_pkg;

  // ASCII codes used by the codec
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChNl    = 8'h0A;
  localparam logic [7:0] ChHash  = 8'h23;
  localparam logic [7:0] ChDot   = 8'h2A;
  localparam logic [7:0] ChDash  = 8'h2D;

  // Longest code held in the symbol register; the length counter saturates one above
  localparam int unsigned MaxSymbols = 7;
  localparam int unsigned MaxResults = 8;
  localparam logic [3:0]  LenMax     = 4'd7;
  localparam logic [3:0]  LenSat     = 4'd8;

  // Mode register values
  localparam logic ModeEncode = 1'b0;
  localparam logic ModeDecode = 1'b1;

  // Work handed from the front to the back: up to eight bytes to emit, in order
  typedef struct packed {
    logic [3:0]                       count;
    logic [MaxResults-1:0][7:0]       bytes;
  } job_t;

  // Encoder lookup result: symbol bit i set means symbol i is a dash
  typedef struct packed {
    logic       hit;
    logic       ws;
    logic [2:0] len;
    logic [6:0] sym;
  } enc_code_t;

  // Text character to Morse code, first table row wins
  function automatic enc_code_t enc_lookup(logic [7:0] ch);
    enc_code_t r;
    r.hit = 1'b1;
    r.ws  = 1'b0;
    r.len = 3'd0;
    r.sym = 7'b0;
    unique case (ch)
      8'h41, 8'h61: begin r.len = 3'd2; r.sym = 7'b0000010; end // A
      8'h42, 8'h62: begin r.len = 3'd4; r.sym = 7'b0000001; end // B
      8'h43, 8'h63: begin r.len = 3'd4; r.sym = 7'b0000101; end // C
      8'h44, 8'h64: begin r.len = 3'd3; r.sym = 7'b0000001; end // D
      8'h45, 8'h65: begin r.len = 3'd1; r.sym = 7'b0000000; end // E
      8'h46, 8'h66: begin r.len = 3'd4; r.sym = 7'b0000100; end // F
      8'h47, 8'h67: begin r.len = 3'd3; r.sym = 7'b0000011; end // G
      8'h48, 8'h68: begin r.len = 3'd4; r.sym = 7'b0000000; end // H
      8'h49, 8'h69: begin r.len = 3'd2; r.sym = 7'b0000000; end // I
      8'h4A, 8'h6A: begin r.len = 3'd4; r.sym = 7'b0001110; end // J
      8'h4B, 8'h6B: begin r.len = 3'd3; r.sym = 7'b0000101; end // K
      8'h4C, 8'h6C: begin r.len = 3'd4; r.sym = 7'b0000010; end // L
      8'h4D, 8'h6D: begin r.len = 3'd2; r.sym = 7'b0000011; end // M
      8'h4E, 8'h6E: begin r.len = 3'd2; r.sym = 7'b0000001; end // N
      8'h4F, 8'h6F: begin r.len = 3'd3; r.sym = 7'b0000111; end // O
      8'h50, 8'h70: begin r.len = 3'd4; r.sym = 7'b0000110; end // P
      8'h51, 8'h71: begin r.len = 3'd4; r.sym = 7'b0001011; end // Q
      8'h52, 8'h72: begin r.len = 3'd3; r.sym = 7'b0000010; end // R
      8'h53, 8'h73: begin r.len = 3'd3; r.sym = 7'b0000000; end // S
      8'h54, 8'h74: begin r.len = 3'd1; r.sym = 7'b0000001; end // T
      8'h55, 8'h75: begin r.len = 3'd3; r.sym = 7'b0000100; end // U
      8'h56, 8'h76: begin r.len = 3'd4; r.sym = 7'b0001000; end // V
      8'h57, 8'h77: begin r.len = 3'd3; r.sym = 7'b0000110; end // W
      8'h58, 8'h78: begin r.len = 3'd4; r.sym = 7'b0001001; end // X
      8'h59, 8'h79: begin r.len = 3'd4; r.sym = 7'b0001101; end // Y
      8'h5A, 8'h7A: begin r.len = 3'd4; r.sym = 7'b0000011; end // Z
      8'h23:        begin r.len = 3'd4; r.sym = 7'b0000111; end // #
      8'h2A:        begin r.len = 3'd4; r.sym = 7'b0001100; end // *
      8'h29:        begin r.len = 3'd6; r.sym = 7'b0101101; end // )
      8'h31:        begin r.len = 3'd5; r.sym = 7'b0011110; end // 1
      8'h32:        begin r.len = 3'd5; r.sym = 7'b0011100; end // 2
      8'h33:        begin r.len = 3'd5; r.sym = 7'b0011000; end // 3
      8'h34:        begin r.len = 3'd5; r.sym = 7'b0010000; end // 4
      8'h35:        begin r.len = 3'd5; r.sym = 7'b0000000; end // 5
      8'h36:        begin r.len = 3'd5; r.sym = 7'b0000001; end // 6
      8'h37:        begin r.len = 3'd5; r.sym = 7'b0000011; end // 7
      8'h38:        begin r.len = 3'd5; r.sym = 7'b0000111; end // 8
      8'h39:        begin r.len = 3'd5; r.sym = 7'b0001111; end // 9
      8'h30:        begin r.len = 3'd5; r.sym = 7'b0011111; end // 0
      8'h2E:        begin r.len = 3'd6; r.sym = 7'b0101010; end // .
      8'h2C:        begin r.len = 3'd6; r.sym = 7'b0110011; end // ,
      8'h21:        begin r.len = 3'd6; r.sym = 7'b0110101; end // !
      8'h3F:        begin r.len = 3'd6; r.sym = 7'b0001100; end // ?
      8'h27:        begin r.len = 3'd6; r.sym = 7'b0011110; end // '
      8'h22:        begin r.len = 3'd6; r.sym = 7'b0010010; end // "
      8'h3B:        begin r.len = 3'd6; r.sym = 7'b0010101; end // ;
      8'h3A:        begin r.len = 3'd6; r.sym = 7'b0000111; end // :
      8'h2D:        begin r.len = 3'd6; r.sym = 7'b0100001; end // -
      8'h2B:        begin r.len = 3'd5; r.sym = 7'b0001010; end // +
      8'h5F:        begin r.len = 3'd6; r.sym = 7'b0101100; end // _
      8'h2F:        begin r.len = 3'd5; r.sym = 7'b0001001; end // /
      8'h28:        begin r.len = 3'd5; r.sym = 7'b0001101; end // (
      8'h26:        begin r.len = 3'd5; r.sym = 7'b0000010; end // &
      8'h24:        begin r.len = 3'd7; r.sym = 7'b1001000; end // $
      8'h40:        begin r.len = 3'd6; r.sym = 7'b0010110; end // @
      8'h20, 8'h09, 8'h0A: begin r.ws = 1'b1; end             // whitespace codes as itself
      default:      begin r.hit = 1'b0; end
    endcase
    return r;
  endfunction

  // Morse code (length 1..7, symbols) to character, '#' when no row matches
  function automatic logic [7:0] dec_lookup(logic [2:0] len, logic [6:0] sym);
    logic [7:0] ch;
    unique case ({len, sym})
      {3'd1, 7'b0000000}: ch = 8'h45; // E
      {3'd1, 7'b0000001}: ch = 8'h54; // T
      {3'd2, 7'b0000010}: ch = 8'h41; // A
      {3'd2, 7'b0000000}: ch = 8'h49; // I
      {3'd2, 7'b0000011}: ch = 8'h4D; // M
      {3'd2, 7'b0000001}: ch = 8'h4E; // N
      {3'd3, 7'b0000110}: ch = 8'h57; // W
      {3'd3, 7'b0000011}: ch = 8'h47; // G
      {3'd3, 7'b0000001}: ch = 8'h44; // D
      {3'd3, 7'b0000101}: ch = 8'h4B; // K
      {3'd3, 7'b0000111}: ch = 8'h4F; // O
      {3'd3, 7'b0000010}: ch = 8'h52; // R
      {3'd3, 7'b0000000}: ch = 8'h53; // S
      {3'd3, 7'b0000100}: ch = 8'h55; // U
      {3'd4, 7'b0000001}: ch = 8'h42; // B
      {3'd4, 7'b0001000}: ch = 8'h56; // V
      {3'd4, 7'b0000011}: ch = 8'h5A; // Z
      {3'd4, 7'b0001110}: ch = 8'h4A; // J
      {3'd4, 7'b0000010}: ch = 8'h4C; // L
      {3'd4, 7'b0000110}: ch = 8'h50; // P
      {3'd4, 7'b0000100}: ch = 8'h46; // F
      {3'd4, 7'b0000000}: ch = 8'h48; // H
      {3'd4, 7'b0000101}: ch = 8'h43; // C
      {3'd4, 7'b0001011}: ch = 8'h51; // Q
      {3'd4, 7'b0001101}: ch = 8'h59; // Y
      {3'd4, 7'b0001001}: ch = 8'h58; // X
      {3'd4, 7'b0001100}: ch = 8'h2A; // *
      {3'd5, 7'b0011110}: ch = 8'h31; // 1
      {3'd5, 7'b0011100}: ch = 8'h32; // 2
      {3'd5, 7'b0011000}: ch = 8'h33; // 3
      {3'd5, 7'b0010000}: ch = 8'h34; // 4
      {3'd5, 7'b0000000}: ch = 8'h35; // 5
      {3'd5, 7'b0000001}: ch = 8'h36; // 6
      {3'd5, 7'b0000011}: ch = 8'h37; // 7
      {3'd5, 7'b0000111}: ch = 8'h38; // 8
      {3'd5, 7'b0001111}: ch = 8'h39; // 9
      {3'd5, 7'b0011111}: ch = 8'h30; // 0
      {3'd5, 7'b0001010}: ch = 8'h2B; // +
      {3'd5, 7'b0001001}: ch = 8'h2F; // /
      {3'd5, 7'b0001101}: ch = 8'h28; // (
      {3'd5, 7'b0000010}: ch = 8'h26; // &
      {3'd6, 7'b0101101}: ch = 8'h29; // )
      {3'd6, 7'b0101010}: ch = 8'h2E; // .
      {3'd6, 7'b0110011}: ch = 8'h2C; // ,
      {3'd6, 7'b0110101}: ch = 8'h21; // !
      {3'd6, 7'b0001100}: ch = 8'h3F; // ?
      {3'd6, 7'b0011110}: ch = 8'h27; // '
      {3'd6, 7'b0010010}: ch = 8'h22; // "
      {3'd6, 7'b0010101}: ch = 8'h3B; // ;
      {3'd6, 7'b0000111}: ch = 8'h3A; // :
      {3'd6, 7'b0100001}: ch = 8'h2D; // -
      {3'd6, 7'b0101100}: ch = 8'h5F; // _
      {3'd6, 7'b0010110}: ch = 8'h40; // @
      {3'd7, 7'b1001000}: ch = 8'h24; // $
      default:            ch = ChHash;
    endcase
    return ch;
  endfunction

  // Character for a closed code: space when empty, '#' when invalid or too long
  function automatic logic [7:0] close_char(logic [3:0] len, logic [6:0] sym, logic inv);
    logic [7:0] ch;
    if (len == 4'd0) begin
      ch = ChSpace;
    end else if (inv || (len > LenMax)) begin
      ch = ChHash;
    end else begin
      ch = dec_lookup(len[2:0], sym);
    end
    return ch;
  endfunction

endpackage

`default_nettype wire

@@ src/mtc_front.sv @@
// Front end: accepts input bytes, holds mode and decode state, builds output jobs.
`default_nettype none

module mtc_front (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         cfg_we_i,
  input  wire logic         cfg_wdata_i,
  input  wire logic         in_valid_i,
  output logic              in_ready_o,
  input  wire logic [7:0]   in_byte_i,
  input  wire logic         in_eom_i,
  input  wire logic         q_full_i,
  output logic              q_push_o,
  output mtc_pkg::job_t     q_job_o
);

  logic       mode_q;
  logic [6:0] sym_q, sym_d;
  logic [3:0] len_q, len_d;
  logic       inv_q, inv_d;

  logic                 accept;
  logic                 is_ws;
  logic                 is_sym;
  logic [6:0]           sym_upd;
  logic [3:0]           len_upd;
  logic                 inv_upd;
  mtc_pkg::enc_code_t   enc;
  mtc_pkg::job_t        enc_job;
  mtc_pkg::job_t        dec_job;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && !q_full_i;

  assign is_ws  = (in_byte_i == mtc_pkg::ChSpace) || (in_byte_i == mtc_pkg::ChTab) ||
                  (in_byte_i == mtc_pkg::ChNl);
  assign is_sym = (in_byte_i == mtc_pkg::ChDot) || (in_byte_i == mtc_pkg::ChDash);

  // Code state after taking one symbol byte
  always_comb begin
    sym_upd = sym_q;
    if ((len_q < mtc_pkg::LenMax) && (in_byte_i == mtc_pkg::ChDash)) begin
      sym_upd[len_q[2:0]] = 1'b1;
    end
    inv_upd = inv_q || !is_sym;
    len_upd = (len_q < mtc_pkg::LenSat) ? len_q + 4'd1 : len_q;
  end

  // Encode job: symbols, whitespace itself or '#' for an unknown byte, then a trailing space
  assign enc = mtc_pkg::enc_lookup(in_byte_i);

  always_comb begin
    enc_job.bytes = {mtc_pkg::MaxResults{mtc_pkg::ChSpace}};
    if (enc.ws) begin
      enc_job.bytes[0] = in_byte_i;
      enc_job.count    = 4'd2;
    end else if (!enc.hit) begin
      enc_job.bytes[0] = mtc_pkg::ChHash;
      enc_job.count    = 4'd2;
    end else begin
      for (int i = 0; i < mtc_pkg::MaxSymbols; i++) begin
        if (3'(i) < enc.len) begin
          enc_job.bytes[i] = enc.sym[i] ? mtc_pkg::ChDash : mtc_pkg::ChDot;
        end
      end
      enc_job.count = {1'b0, enc.len} + 4'd1;
    end
  end

  // Decode job and next decode state
  always_comb begin
    dec_job.bytes = {mtc_pkg::MaxResults{mtc_pkg::ChSpace}};
    dec_job.count = 4'd0;
    sym_d = sym_q;
    len_d = len_q;
    inv_d = inv_q;
    if (is_ws) begin
      // close pending code, echo tab or newline, then the empty close on end of message
      dec_job.bytes[0] = mtc_pkg::close_char(len_q, sym_q, inv_q);
      dec_job.bytes[1] = in_byte_i;
      dec_job.count    = 4'd1 + {3'b0, (in_byte_i != mtc_pkg::ChSpace)} + {3'b0, in_eom_i};
      sym_d = 7'b0;
      len_d = 4'd0;
      inv_d = 1'b0;
    end else if (in_eom_i) begin
      dec_job.bytes[0] = mtc_pkg::close_char(len_upd, sym_upd, inv_upd);
      dec_job.count    = 4'd1;
      sym_d = 7'b0;
      len_d = 4'd0;
      inv_d = 1'b0;
    end else begin
      sym_d = sym_upd;
      len_d = len_upd;
      inv_d = inv_upd;
    end
  end

  assign q_job_o  = (mode_q == mtc_pkg::ModeDecode) ? dec_job : enc_job;
  assign q_push_o = accept && (q_job_o.count != 4'd0);

  // Mode register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= mtc_pkg::ModeEncode;
    end else if (cfg_we_i) begin
      mode_q <= cfg_wdata_i;
    end
  end

  // Decode state, touched only by decode-mode transactions
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sym_q <= 7'b0;
      len_q <= 4'd0;
      inv_q <= 1'b0;
    end else if (accept && (mode_q == mtc_pkg::ModeDecode)) begin
      sym_q <= sym_d;
      len_q <= len_d;
      inv_q <= inv_d;
    end
  end

endmodule

`default_nettype wire

@@ src/mtc_queue.sv @@
// Small register FIFO of jobs between the front and the back.
`default_nettype none

module mtc_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire mtc_pkg::job_t push_job_i,
  output logic               full_o,
  input  wire logic          pop_i,
  output logic               valid_o,
  output mtc_pkg::job_t      head_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  mtc_pkg::job_t   mem_q [DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(DEPTH));
  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // Pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Entry storage, no reset
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_job_i;
    end
  end

endmodule

`default_nettype wire

@@ src/mtc_back.sv @@
// Back end: walks the head job and sends one output byte per transaction.
`default_nettype none

module mtc_back (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          q_valid_i,
  input  wire mtc_pkg::job_t q_head_i,
  output logic               q_pop_o,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output logic [7:0]         out_byte_o,
  output logic               out_last_o
);

  logic [2:0] idx_q, idx_d;
  logic       fire;

  assign out_valid_o = q_valid_i;
  assign out_byte_o  = q_head_i.bytes[idx_q];
  assign out_last_o  = ({1'b0, idx_q} == (q_head_i.count - 4'd1));
  assign fire        = q_valid_i && out_ready_i;
  assign q_pop_o     = fire && out_last_o;

  // Byte index within the head job
  always_comb begin
    idx_d = idx_q;
    if (fire) begin
      idx_d = out_last_o ? 3'd0 : idx_q + 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= 3'd0;
    end else begin
      idx_q <= idx_d;
    end
  end

endmodule

`default_nettype wire

@@ src/morse_text_codec_core.sv @@
// Top level of the Morse text codec: front end, job queue and output serializer.
//
// Usage:
//   Input stream (s_axis_*): one character byte per transaction in tdata; tlast is the
//   end-of-message flag that closes a pending code in decode mode.
//   Output stream (m_axis_*): one character byte per transaction; tlast marks the final
//   byte produced by an input transaction.
//   cfg_we_i/cfg_wdata_i write the mode bit (0 encode, 1 decode); write only when idle.
// Output: an input's first byte is valid once its queued job reaches the queue head.
// Throughput: the serializer sends one byte per cycle while a job is queued and tready is
//   high; an input produces as many bytes as its job holds: encode 2 to 8 bytes,
//   decode 0 to 3 bytes (a symbol byte that closes nothing produces no byte).
//   The front accepts while the queue (QUEUE_DEPTH jobs) has room, even when the output
//   is stalled; when the receiver holds tready low the queue fills and s_axis_tready drops.
// Reset: mode returns to encode, decode state is cleared and the queue is emptied.
`default_nettype none

module morse_text_codec_core #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_wdata_i,     // mode
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,    // [7:0] in_byte
  input  wire logic        s_axis_tlast,    // end_of_message
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [7:0]       m_axis_tdata,    // [7:0] out_byte
  output logic             m_axis_tlast     // last
);

  logic           q_push;
  logic           q_full;
  logic           q_pop;
  logic           q_valid;
  mtc_pkg::job_t  q_job;
  mtc_pkg::job_t  q_head;

  mtc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_byte_i   (s_axis_tdata),
    .in_eom_i    (s_axis_tlast),
    .q_full_i    (q_full),
    .q_push_o    (q_push),
    .q_job_o     (q_job)
  );

  mtc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (q_push),
    .push_job_i (q_job),
    .full_o     (q_full),
    .pop_i      (q_pop),
    .valid_o    (q_valid),
    .head_o     (q_head)
  );

  mtc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_head_i    (q_head),
    .q_pop_o     (q_pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_byte_o  (m_axis_tdata),
    .out_last_o  (m_axis_tlast)
  );

endmodule

`default_nettype wire

@@ tb/sv/morse_text_codec_core_tb.sv @@
// Self-checking testbench for the Morse text codec core with random backpressure.
`default_nettype none

module morse_text_codec_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RowCount    = 96;
  localparam int unsigned SymbolRows  = 93;   // rows before the whitespace entries
  localparam int unsigned DrainCycles = 12;

  // One output transaction as the checker sees it
  typedef struct packed {
    logic [7:0] ch;
    logic       is_last;
  } morse_out_t;

  logic       clk_i = 1'b0;
  logic       rst_ni;
  logic       cfg_we_i;
  logic       cfg_wdata_i;
  logic       s_axis_tvalid;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata;
  logic       s_axis_tlast;
  logic       m_axis_tvalid;
  logic       m_axis_tready;
  logic [7:0] m_axis_tdata;
  logic       m_axis_tlast;

  // Character table, searched first row first
  logic [7:0] row_char [RowCount] = '{
    "A", "B", "W", "G", "D", "E", "V", "Z", "I", "J", "K", "L", "M", "N", "O", "P",
    "R", "S", "T", "U", "F", "H", "C", "#", "#", "Q", "#", "Y", "X", "#", "*", "#",
    ")",
    "a", "b", "w", "g", "d", "e", "v", "z", "i", "j", "k", "l", "m", "n", "o", "p",
    "r", "s", "t", "u", "f", "h", "c", "#", "#", "q", "#", "y", "x", "#", "*", "#",
    "1", "2", "3", "4", "5", "6", "7", "8", "9", "0", "#", ".", ",", "!", "?", "'",
    "\"", ";", ":", "-", "+", "_", "/", "(", ")", "&", "$", "@",
    " ", "\n", "\t"
  };

  string row_code [RowCount] = '{
    "*-", "-***", "*--", "--*", "-**", "*", "***-", "--**", "**", "*---", "-*-", "*-**",
    "--", "-*", "---", "*--*", "*-*", "***", "-", "**-", "**-*", "****", "-*-*", "---*",
    "----", "--*-", "--*--", "-*--", "-**-", "**-**", "**--", "*-*-", "-*--*-",
    "*-", "-***", "*--", "--*", "-**", "*", "***-", "--**", "**", "*---", "-*-", "*-**",
    "--", "-*", "---", "*--*", "*-*", "***", "-", "**-", "**-*", "****", "-*-*", "---*",
    "----", "--*-", "--*--", "-*--", "-**-", "**-**", "**--", "*-*-",
    "*----", "**---", "***--", "****-", "*****", "-****", "--***", "---**", "----*",
    "-----", "******", "*-*-*-", "--**--", "-*-*--", "**--**", "*----*", "*-**-*",
    "-*-*-*", "---***", "-****-", "*-*-*", "**--*-", "-**-*", "-*--*", "-*--*-",
    "*-***", "***-**-", "*--*-*",
    " ", "\n", "\t"
  };

  // Predictor state: mode register and the pending decode code
  logic       cur_mode = mtc_pkg::ModeEncode;
  logic [6:0] pend_sym = '0;
  logic [3:0] pend_len = '0;
  logic       pend_bad = 1'b0;

  morse_out_t expected_chars[$];
  int         n_fail = 0;

  morse_text_codec_core u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic void push_char(logic [7:0] ch);
    morse_out_t r;
    r.ch      = ch;
    r.is_last = 1'b0;
    expected_chars.push_back(r);
  endfunction

  // True when the pending code spells exactly this table code
  function automatic bit pending_matches(string code);
    if (code.len() != pend_len) return 1'b0;
    for (int i = 0; i < code.len(); i++) begin
      if (code[i] != (pend_sym[i] ? mtc_pkg::ChDash : mtc_pkg::ChDot)) return 1'b0;
    end
    return 1'b1;
  endfunction

  // Close the pending code: space when empty, '#' when broken or too long
  function automatic void close_pending_code();
    logic [7:0] ch;
    ch = mtc_pkg::ChHash;
    if (pend_len == 0) begin
      ch = mtc_pkg::ChSpace;
    end else if (!pend_bad && pend_len <= mtc_pkg::MaxSymbols) begin
      for (int j = 0; j < RowCount; j++) begin
        if (pending_matches(row_code[j])) begin
          ch = row_char[j];
          break;
        end
      end
    end
    push_char(ch);
    pend_sym = '0;
    pend_len = '0;
    pend_bad = 1'b0;
  endfunction

  // Work out every output byte that one accepted input causes
  function automatic void predict_morse_output(logic [7:0] b, logic eom);
    string code;
    int    n_before;
    n_before = expected_chars.size();
    if (cur_mode == mtc_pkg::ModeEncode) begin
      code = "#";
      for (int j = 0; j < RowCount; j++) begin
        if (row_char[j] == b) begin
          code = row_code[j];
          break;
        end
      end
      for (int i = 0; i < mtc_pkg::MaxSymbols && i < code.len(); i++) push_char(code[i]);
      push_char(mtc_pkg::ChSpace);
    end else begin
      if (b == mtc_pkg::ChSpace || b == mtc_pkg::ChTab || b == mtc_pkg::ChNl) begin
        close_pending_code();
        if (b != mtc_pkg::ChSpace) push_char(b);
      end else begin
        if (b == mtc_pkg::ChDot || b == mtc_pkg::ChDash) begin
          if (pend_len < mtc_pkg::MaxSymbols && b == mtc_pkg::ChDash) pend_sym[pend_len] = 1'b1;
        end else begin
          pend_bad = 1'b1;
        end
        if (pend_len < mtc_pkg::LenSat) pend_len = pend_len + 1'b1;
      end
      if (eom) close_pending_code();
    end
    if (expected_chars.size() > n_before) expected_chars[expected_chars.size() - 1].is_last = 1'b1;
  endfunction

  // Predict on input transactions, check output transactions, follow mode writes
  always @(posedge clk_i) begin
    morse_out_t want;
    if (!rst_ni) begin
      cur_mode = mtc_pkg::ModeEncode;
      pend_sym = '0;
      pend_len = '0;
      pend_bad = 1'b0;
    end else begin
      if (cfg_we_i) cur_mode = cfg_wdata_i;
      if (s_axis_tvalid && s_axis_tready) predict_morse_output(s_axis_tdata, s_axis_tlast);
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_chars.size() == 0) begin
          $display("%0t: unexpected output: expected nothing, got byte %h last %b",
                   $time, m_axis_tdata, m_axis_tlast);
          n_fail++;
        end else begin
          want = expected_chars.pop_front();
          if (m_axis_tdata !== want.ch || m_axis_tlast !== want.is_last) begin
            $display("%0t: mismatch: expected byte %h last %b, got byte %h last %b",
                     $time, want.ch, want.is_last, m_axis_tdata, m_axis_tlast);
            n_fail++;
          end
        end
      end
    end
  end

  // Receiver backpressure: mostly short stalls, some long ones, some long clear runs
  initial begin : rx_ready_gen
    int run_len;
    int stall_len;
    m_axis_tready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      run_len = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 6);
      m_axis_tready <= 1'b1;
      repeat (run_len) @(posedge clk_i);
      stall_len = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 3);
      m_axis_tready <= 1'b0;
      repeat (stall_len) @(posedge clk_i);
    end
  end

  // Sender idle time between transactions
  function automatic int sender_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // One input transaction, then an optional idle gap
  task automatic send_byte(input logic [7:0] b, input logic eom);
    int gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= eom;
    do @(posedge clk_i); while (!s_axis_tready);
    gap = sender_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Send a symbol string, optionally closing it with end-of-message on the last byte
  task automatic send_symbols(input string s, input logic eom_last);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], eom_last && (i == s.len() - 1));
  endtask

  // Stop sending and let all outstanding output drain
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (expected_chars.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_mode(input logic m);
    wait_idle();
    cfg_wdata_i <= m;
    cfg_we_i    <= 1'b1;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // Encode corners: lowercase, longest code, table '#', whitespace, unknown bytes
  task automatic test_encode_directed();
    write_mode(mtc_pkg::ModeEncode);
    send_byte("z", 1'b0);
    send_byte("$", 1'b0);
    send_byte("#", 1'b0);
    send_byte(mtc_pkg::ChSpace, 1'b0);
    send_byte(mtc_pkg::ChTab, 1'b0);
    send_byte(mtc_pkg::ChNl, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b1);   // end-of-message has no effect here
  endtask

  // Decode corners: longest code, overflow, stray byte, empty code, double close
  task automatic test_decode_directed();
    write_mode(mtc_pkg::ModeDecode);
    send_symbols("***-**-", 1'b0);
    send_byte(mtc_pkg::ChNl, 1'b0);
    send_symbols("********", 1'b1);
    send_symbols("*%", 1'b0);
    send_byte(mtc_pkg::ChTab, 1'b0);
    send_byte(mtc_pkg::ChSpace, 1'b0);
    send_symbols("-", 1'b1);
    send_byte(mtc_pkg::ChSpace, 1'b1);
    send_byte(mtc_pkg::ChNl, 1'b1);
  endtask

  // Random text: table characters mixed with arbitrary bytes
  task automatic test_encode_random(input int n_items);
    logic [7:0] b;
    write_mode(mtc_pkg::ModeEncode);
    for (int k = 0; k < n_items; k++) begin
      if ($urandom_range(0, 1) == 0) b = row_char[$urandom_range(0, RowCount - 1)];
      else b = 8'($urandom_range(0, 255));
      send_byte(b, 1'($urandom_range(0, 1)));
    end
  endtask

  // Random Morse: mostly valid codes with terminators, plus overflow, noise and broken codes
  task automatic test_decode_random(input int n_items);
    int    sent;
    int    kind;
    int    n_sym;
    string code;
    logic  eom_close;
    logic [7:0] term;
    write_mode(mtc_pkg::ModeDecode);
    sent = 0;
    while (sent < n_items) begin
      kind = $urandom_range(0, 9);
      code = "";
      if (kind <= 6) begin
        code = row_code[$urandom_range(0, SymbolRows - 1)];
      end else if (kind == 7) begin
        n_sym = $urandom_range(8, 10);
        for (int i = 0; i < n_sym; i++) begin
          code = {code, string'(($urandom_range(0, 1) != 0) ? mtc_pkg::ChDash : mtc_pkg::ChDot)};
        end
      end else if (kind == 9) begin
        n_sym = $urandom_range(1, 4);
        for (int i = 0; i < n_sym; i++) begin
          code = {code, string'(($urandom_range(0, 1) != 0) ? mtc_pkg::ChDash : mtc_pkg::ChDot)};
        end
        code = {code, string'(8'($urandom_range(0, 255)))};
      end
      if (kind == 8) begin
        send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        sent++;
      end else begin
        eom_close = ($urandom_range(0, 3) == 0);
        send_symbols(code, eom_close);
        sent += code.len();
        if (!eom_close) begin
          case ($urandom_range(0, 2))
            0:       term = mtc_pkg::ChSpace;
            1:       term = mtc_pkg::ChTab;
            default: term = mtc_pkg::ChNl;
          endcase
          send_byte(term, $urandom_range(0, 7) == 0);
          sent++;
        end
      end
    end
  endtask

  initial begin
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tlast  <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_wdata_i   <= mtc_pkg::ModeEncode;
    rst_ni        <= 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni        <= 1'b1;
    @(posedge clk_i);

    test_encode_directed();
    test_decode_directed();
    test_encode_random(32);
    test_decode_random(36);
    test_encode_random(32);
    test_decode_random(36);
    wait_idle();

    if (n_fail == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Guard against a hung handshake
  initial begin
    #4_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

`default_nettype wire
